/* hdl/lbpe_pkg.sv */
// shared codes and constants for the led blink pattern engine
package lbpe_pkg;

  // widths fixed by the item and register layout
  localparam int OPCODE_W  = 2;
  localparam int INDEX_W   = 3;
  localparam int MODE_W    = 3;
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 3;
  localparam int FLASH_W   = 3;
  localparam int IN_DW     = 8;

  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [MODE_W-1:0]    mode_code_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  // input opcodes
  localparam opcode_t OP_TICK    = 2'd0;
  localparam opcode_t OP_SET_ONE = 2'd1;
  localparam opcode_t OP_SET_ALL = 2'd2;

  // led modes
  localparam mode_code_t MODE_OFF   = 3'd0;
  localparam mode_code_t MODE_ON    = 3'd1;
  localparam mode_code_t MODE_SLOW  = 3'd2;
  localparam mode_code_t MODE_FAST  = 3'd3;
  localparam mode_code_t MODE_RAPID = 3'd4;
  localparam mode_code_t MODE_FLASH = 3'd5;
  localparam mode_code_t MODE_HEART = 3'd6;

  // configuration register indexes
  localparam reg_idx_t REG_SLOW_HALF  = 3'd0;
  localparam reg_idx_t REG_FAST_HALF  = 3'd1;
  localparam reg_idx_t REG_RAPID_HALF = 3'd2;
  localparam reg_idx_t REG_PAUSE      = 3'd3;
  localparam reg_idx_t REG_HB_CYCLE   = 3'd4;

  // register reset values
  localparam cfg_word_t SLOW_HALF_RST  = 11'd1000;
  localparam cfg_word_t FAST_HALF_RST  = 11'd250;
  localparam cfg_word_t RAPID_HALF_RST = 11'd100;
  localparam cfg_word_t PAUSE_RST      = 11'd1000;
  localparam cfg_word_t HB_CYCLE_RST   = 11'd2000;

  // error flash burst length and heartbeat lit windows
  localparam logic [FLASH_W-1:0] FLASH_BURST = 3'd6;
  localparam int HB_FIRST_END    = 100;
  localparam int HB_SECOND_START = 200;
  localparam int HB_SECOND_END   = 300;

endpackage

/* hdl/led_blink_pattern_engine.sv */
// Takes one beat per clock cycle while s_tready is high, and registers the result of each input
// beat. Each beat is a 1 ms tick, a mode set for one LED or a mode set for all LEDs. The new
// per-LED timer, phase, flash count and level state is worked out in one pass of parallel
// logic, one slice per LED, and is registered together with the result. A two-entry output
// buffer (result register plus skid register) keeps input ready high while one result is
// stalled on the output side, so a stalled consumer does not hold up input until a second result
// is waiting. Every beat gives exactly one result: the LED levels and a mask of the levels that
// changed. A mode set clears the LED's timer, flash count and phase and reports no change.
// There is no clearing pass: everything is ready in the cycle after reset.
module led_blink_pattern_engine #(
  parameter int NUM_LEDS   = 6,
  parameter int TIMER_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  // input beat, from the lowest bit: opcode[1:0], led_index[4:2], new_mode[7:5]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lbpe_pkg::IN_DW-1:0]    s_tdata,
  // result beat, from the lowest bit: led_levels, changed_mask, zero fill
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [((2*NUM_LEDS+7)/8)*8-1:0] m_tdata,
  // configuration writes
  input  logic                          wr_en,
  input  logic [lbpe_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [lbpe_pkg::CFG_W-1:0]    wr_data
);
  import lbpe_pkg::*;

  localparam int OUT_DW = ((2*NUM_LEDS+7)/8)*8;
  localparam int RES_W  = 2*NUM_LEDS;
  localparam int CMP_W  = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int HB_CW  = (TIMER_BITS > 9) ? TIMER_BITS : 9;

  // input fields
  opcode_t          in_opcode;
  logic [INDEX_W-1:0] in_index;
  mode_code_t       in_mode;
  logic             accept;

  assign in_opcode = s_tdata[1:0];
  assign in_index  = s_tdata[4:2];
  assign in_mode   = s_tdata[7:5];
  assign accept    = s_tvalid && s_tready;

  // configuration registers
  cfg_word_t slow_half;
  cfg_word_t fast_half;
  cfg_word_t rapid_half;
  cfg_word_t flash_pause;
  cfg_word_t hb_cycle;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_half   <= SLOW_HALF_RST;
      fast_half   <= FAST_HALF_RST;
      rapid_half  <= RAPID_HALF_RST;
      flash_pause <= PAUSE_RST;
      hb_cycle    <= HB_CYCLE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SLOW_HALF:  slow_half   <= wr_data;
        REG_FAST_HALF:  fast_half   <= wr_data;
        REG_RAPID_HALF: rapid_half  <= wr_data;
        REG_PAUSE:      flash_pause <= wr_data;
        REG_HB_CYCLE:   hb_cycle    <= wr_data;
        default: ;
      endcase
    end
  end

  // per-led state
  mode_code_t             led_mode      [NUM_LEDS];
  logic [TIMER_BITS-1:0]  elapsed       [NUM_LEDS];
  logic                   blink_phase   [NUM_LEDS];
  logic [FLASH_W-1:0]     flash_toggles [NUM_LEDS];
  logic [TIMER_BITS-1:0]  hb_count;
  logic [NUM_LEDS-1:0]    level_reg;

  mode_code_t             led_mode_next      [NUM_LEDS];
  logic [TIMER_BITS-1:0]  elapsed_next       [NUM_LEDS];
  logic                   blink_phase_next   [NUM_LEDS];
  logic [FLASH_W-1:0]     flash_toggles_next [NUM_LEDS];
  logic [TIMER_BITS-1:0]  hb_count_next;
  logic [NUM_LEDS-1:0]    level_reg_next;

  logic [TIMER_BITS-1:0]  hb_inc;
  logic [HB_CW-1:0]       hb_wide;
  logic                   hb_lit;
  logic                   set_one_ok;

  // half period of a square blink mode
  function automatic cfg_word_t half_for(input mode_code_t m, input cfg_word_t slow,
                                         input cfg_word_t fast, input cfg_word_t rapid);
    cfg_word_t h;
    case (m)
      MODE_SLOW: h = slow;
      MODE_FAST: h = fast;
      default:   h = rapid;
    endcase
    return h;
  endfunction

  // heartbeat counter and lit window
  always_comb begin
    hb_inc = hb_count + 1'b1;
    if (CMP_W'(hb_inc) >= CMP_W'(hb_cycle)) begin
      hb_count_next = '0;
    end else begin
      hb_count_next = hb_inc;
    end
    hb_wide = HB_CW'(hb_count_next);
    hb_lit  = (hb_wide < HB_CW'(HB_FIRST_END)) ||
              ((hb_wide >= HB_CW'(HB_SECOND_START)) && (hb_wide < HB_CW'(HB_SECOND_END)));
    set_one_ok = int'(in_index) < NUM_LEDS;
  end

  // next state of every led, one independent slice each
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_mode_next[i]      = led_mode[i];
      elapsed_next[i]       = elapsed[i];
      blink_phase_next[i]   = blink_phase[i];
      flash_toggles_next[i] = flash_toggles[i];
      level_reg_next[i]     = level_reg[i];
      case (in_opcode)
        OP_TICK: begin
          if (elapsed[i] != {TIMER_BITS{1'b1}}) begin
            elapsed_next[i] = elapsed[i] + 1'b1;
          end
          case (led_mode[i])
            MODE_ON: begin
              level_reg_next[i] = 1'b1;
            end
            MODE_SLOW, MODE_FAST, MODE_RAPID: begin
              if (CMP_W'(elapsed_next[i]) >=
                  CMP_W'(half_for(led_mode[i], slow_half, fast_half, rapid_half))) begin
                blink_phase_next[i] = ~blink_phase[i];
                elapsed_next[i]     = '0;
              end
              level_reg_next[i] = blink_phase_next[i];
            end
            MODE_FLASH: begin
              if (flash_toggles[i] < FLASH_BURST) begin
                if (CMP_W'(elapsed_next[i]) >= CMP_W'(rapid_half)) begin
                  blink_phase_next[i]   = ~blink_phase[i];
                  elapsed_next[i]       = '0;
                  flash_toggles_next[i] = flash_toggles[i] + 1'b1;
                end
                level_reg_next[i] = blink_phase_next[i];
              end else begin
                // pause after the burst, measured from the last toggle
                if (CMP_W'(elapsed_next[i]) >= CMP_W'(flash_pause)) begin
                  flash_toggles_next[i] = '0;
                  blink_phase_next[i]   = 1'b0;
                  elapsed_next[i]       = '0;
                end
                level_reg_next[i] = 1'b0;
              end
            end
            MODE_HEART: begin
              level_reg_next[i] = hb_lit;
            end
            default: begin
              level_reg_next[i] = 1'b0;
            end
          endcase
        end
        OP_SET_ONE, OP_SET_ALL: begin
          if ((in_opcode == OP_SET_ALL) || (set_one_ok && (int'(in_index) == i))) begin
            led_mode_next[i]      = in_mode;
            elapsed_next[i]       = '0;
            blink_phase_next[i]   = 1'b0;
            flash_toggles_next[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers, updated on every accepted beat; the heartbeat counter only on a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]      <= MODE_OFF;
        elapsed[i]       <= '0;
        blink_phase[i]   <= 1'b0;
        flash_toggles[i] <= '0;
      end
      hb_count  <= '0;
      level_reg <= '0;
    end else if (accept) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]      <= led_mode_next[i];
        elapsed[i]       <= elapsed_next[i];
        blink_phase[i]   <= blink_phase_next[i];
        flash_toggles[i] <= flash_toggles_next[i];
      end
      if (in_opcode == OP_TICK) begin
        hb_count <= hb_count_next;
      end
      level_reg <= level_reg_next;
    end
  end

  // result of this beat: changed mask above the levels
  logic [RES_W-1:0] res_new;
  assign res_new = {level_reg_next ^ level_reg, level_reg_next};

  // two-entry output buffer: result register and skid register
  logic             out_valid;
  logic [RES_W-1:0] out_res;
  logic             skid_valid;
  logic [RES_W-1:0] skid_res;
  logic             pop;

  assign pop      = out_valid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DW'(out_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_res <= res_new;
        end
      end
    end else if (!out_valid) begin
      out_valid <= accept;
      if (accept) begin
        out_res <= res_new;
      end
    end else if (accept) begin
      skid_res   <= res_new;
      skid_valid <= 1'b1;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the result register is empty");

  a_set_keeps_levels: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_opcode != OP_TICK)) |=> $stable(level_reg))
    else $error("levels changed on a beat that is not a tick");

  a_set_all_mode: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_opcode == OP_SET_ALL)) |=>
      ((led_mode[0] == $past(in_mode)) && (elapsed[0] == '0)))
    else $error("set-all did not store the mode and clear the timer");

  a_hb_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(accept && (in_opcode == OP_TICK)) |=> $stable(hb_count))
    else $error("heartbeat counter moved without a tick");

  a_result_pushed: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

/* sim/testbench.sv */
// self-checking testbench for the led blink pattern engine
`timescale 1ns / 1ps

module testbench;
  import lbpe_pkg::*;

  localparam int NUM_LEDS    = 6;
  localparam int TIMER_BITS  = 11;
  localparam int OUT_DW      = ((2*NUM_LEDS+7)/8)*8;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;

  // codes the block must treat as unused
  localparam opcode_t    OP_UNUSED   = 2'd3;
  localparam mode_code_t MODE_UNUSED = 3'd7;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam cfg_word_t             CFG_MAX   = '1;

  typedef enum logic [1:0] {STEP_BEAT, STEP_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    opcode_t              op;
    logic [INDEX_W-1:0]   idx;
    mode_code_t           mode;
    reg_idx_t             reg_sel;
    cfg_word_t            value;
  } plan_step_t;

  typedef struct {
    logic [NUM_LEDS-1:0] levels;
    logic [NUM_LEDS-1:0] changed;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DW-1:0]     s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_DW-1:0]    m_tdata;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;

  plan_step_t  stimulus_q[$];
  led_result_t predicted_q[$];

  int beats_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int n_fail       = 0;
  int gap_left     = 0;
  int stall_left   = 0;

  // predictor state and settings
  cfg_word_t             slow_half, fast_half, rapid_half, pause_len, hb_cycle;
  mode_code_t            mode_of     [NUM_LEDS];
  logic [TIMER_BITS-1:0] elapsed_ms  [NUM_LEDS];
  logic                  blink_on    [NUM_LEDS];
  logic [FLASH_W-1:0]    burst_count [NUM_LEDS];
  logic [TIMER_BITS-1:0] hb_count;
  logic [NUM_LEDS-1:0]   lamp_levels;

  led_blink_pattern_engine #(
    .NUM_LEDS   (NUM_LEDS),
    .TIMER_BITS (TIMER_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void restart_led(input int i, input mode_code_t mode);
    mode_of[i]     = mode;
    elapsed_ms[i]  = '0;
    blink_on[i]    = 1'b0;
    burst_count[i] = '0;
  endfunction

  function automatic logic toggle_square(input int i, input cfg_word_t half);
    if (elapsed_ms[i] >= half) begin
      blink_on[i]   = ~blink_on[i];
      elapsed_ms[i] = '0;
    end
    return blink_on[i];
  endfunction

  function automatic void clear_leds();
    slow_half   = SLOW_HALF_RST;
    fast_half   = FAST_HALF_RST;
    rapid_half  = RAPID_HALF_RST;
    pause_len   = PAUSE_RST;
    hb_cycle    = HB_CYCLE_RST;
    hb_count    = '0;
    lamp_levels = '0;
    for (int i = 0; i < NUM_LEDS; i++) restart_led(i, MODE_OFF);
  endfunction

  function automatic void apply_setting(input reg_idx_t sel, input cfg_word_t value);
    case (sel)
      REG_SLOW_HALF:  slow_half  = value;
      REG_FAST_HALF:  fast_half  = value;
      REG_RAPID_HALF: rapid_half = value;
      REG_PAUSE:      pause_len  = value;
      REG_HB_CYCLE:   hb_cycle   = value;
      default: ;
    endcase
  endfunction

  // one input beat: update led state and work out levels and change mask
  function automatic void advance_leds(input opcode_t op, input logic [INDEX_W-1:0] idx,
                                       input mode_code_t mode, output led_result_t res);
    logic [NUM_LEDS-1:0]   prior;
    logic [TIMER_BITS-1:0] hb_next;
    prior = lamp_levels;
    case (op)
      OP_TICK: begin
        hb_next  = hb_count + 1'b1;
        hb_count = (hb_next >= hb_cycle) ? '0 : hb_next;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (elapsed_ms[i] != TIMER_MAX) elapsed_ms[i] = elapsed_ms[i] + 1'b1;
          case (mode_of[i])
            MODE_ON:    lamp_levels[i] = 1'b1;
            MODE_SLOW:  lamp_levels[i] = toggle_square(i, slow_half);
            MODE_FAST:  lamp_levels[i] = toggle_square(i, fast_half);
            MODE_RAPID: lamp_levels[i] = toggle_square(i, rapid_half);
            MODE_FLASH: begin
              if (burst_count[i] < FLASH_BURST) begin
                if (elapsed_ms[i] >= rapid_half) begin
                  blink_on[i]    = ~blink_on[i];
                  elapsed_ms[i]  = '0;
                  burst_count[i] = burst_count[i] + 1'b1;
                end
                lamp_levels[i] = blink_on[i];
              end else begin
                // dark pause, counted from the last toggle of the burst
                if (elapsed_ms[i] >= pause_len) begin
                  burst_count[i] = '0;
                  blink_on[i]    = 1'b0;
                  elapsed_ms[i]  = '0;
                end
                lamp_levels[i] = 1'b0;
              end
            end
            MODE_HEART: lamp_levels[i] = (hb_count < HB_FIRST_END) ||
                                         (hb_count >= HB_SECOND_START && hb_count < HB_SECOND_END);
            default:    lamp_levels[i] = 1'b0;
          endcase
        end
      end
      OP_SET_ONE: if (idx < NUM_LEDS) restart_led(idx, mode);
      OP_SET_ALL: for (int i = 0; i < NUM_LEDS; i++) restart_led(i, mode);
      default: ;
    endcase
    res.levels  = lamp_levels;
    res.changed = lamp_levels ^ prior;
  endfunction

  // ---------------------------------------------------------------- stimulus plan

  function automatic void add_beat(input opcode_t op, input int idx, input mode_code_t mode);
    plan_step_t s;
    s.kind    = STEP_BEAT;
    s.op      = op;
    s.idx     = idx[INDEX_W-1:0];
    s.mode    = mode;
    s.reg_sel = '0;
    s.value   = '0;
    stimulus_q.push_back(s);
  endfunction

  function automatic void add_drain();
    plan_step_t s;
    s.kind    = STEP_DRAIN;
    s.op      = OP_TICK;
    s.idx     = '0;
    s.mode    = MODE_OFF;
    s.reg_sel = '0;
    s.value   = '0;
    stimulus_q.push_back(s);
  endfunction

  function automatic void add_write(input reg_idx_t sel, input cfg_word_t value);
    plan_step_t s;
    s.kind    = STEP_WRITE;
    s.op      = OP_TICK;
    s.idx     = '0;
    s.mode    = MODE_OFF;
    s.reg_sel = sel;
    s.value   = value;
    stimulus_q.push_back(s);
  endfunction

  // new settings only once the block has gone quiet
  function automatic void add_setting(input int slow, input int fast, input int rapid,
                                      input int pause, input int cycle);
    add_drain();
    add_write(REG_SLOW_HALF,  cfg_word_t'(slow));
    add_write(REG_FAST_HALF,  cfg_word_t'(fast));
    add_write(REG_RAPID_HALF, cfg_word_t'(rapid));
    add_write(REG_PAUSE,      cfg_word_t'(pause));
    add_write(REG_HB_CYCLE,   cfg_word_t'(cycle));
  endfunction

  function automatic mode_code_t pick_mode();
    if ($urandom_range(0, 19) == 0) return MODE_UNUSED;
    return mode_code_t'($urandom_range(MODE_OFF, MODE_HEART));
  endfunction

  // mostly ticks so the timers run, with mode changes and some junk mixed in
  function automatic void add_random_beats(input int n);
    int r;
    int idx;
    for (int k = 0; k < n; k++) begin
      if (k == n/2) add_drain();
      r = $urandom_range(0, 99);
      if (r < 78) begin
        add_beat(OP_TICK, $urandom_range(0, 7), mode_code_t'($urandom_range(0, 7)));
      end else if (r < 90) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_LEDS, 7)
                                          : $urandom_range(0, NUM_LEDS-1);
        add_beat(OP_SET_ONE, idx, pick_mode());
      end else if (r < 96) begin
        add_beat(OP_SET_ALL, $urandom_range(0, 7), pick_mode());
      end else begin
        add_beat(OP_UNUSED, $urandom_range(0, 7), mode_code_t'($urandom_range(0, 7)));
      end
    end
  endfunction

  function automatic int draw_wait(input int count);
    // every third run of 64 beats goes without idling
    if (((count >> 6) % 3) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // ---------------------------------------------------------------- input driver

  always @(posedge clk) begin : drive_inputs
    logic       nxt_valid;
    logic       nxt_wr;
    plan_step_t head;
    nxt_valid = s_tvalid;
    nxt_wr    = 1'b0;
    if (rst) begin
      nxt_valid = 1'b0;
      gap_left  = 0;
    end else if (!s_tvalid || s_tready) begin
      nxt_valid = 1'b0;
      if (s_tvalid) beats_sent <= beats_sent + 1;
      if (gap_left > 0) begin
        gap_left--;
      end else if (stimulus_q.size() > 0) begin
        head = stimulus_q[0];
        case (head.kind)
          STEP_BEAT: begin
            nxt_valid = 1'b1;
            s_tdata  <= {head.mode, head.idx, head.op};
            void'(stimulus_q.pop_front());
            gap_left = draw_wait(beats_sent);
          end
          default: begin
            // writes and drains wait until every result is back
            if (!s_tvalid && beats_sent == results_seen) begin
              if (head.kind == STEP_WRITE) begin
                nxt_wr = 1'b1;
                wr_index <= head.reg_sel;
                wr_data  <= head.value;
              end
              void'(stimulus_q.pop_front());
            end
          end
        endcase
      end
    end
    s_tvalid <= nxt_valid;
    wr_en    <= nxt_wr;
  end

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      stall_left = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) stall_left = draw_wait(results_seen);
      else if (stall_left > 0) stall_left--;
      m_tready <= (stall_left == 0);
    end
  end

  // predict on every accepted input beat and register write
  always @(posedge clk) begin : predict_levels
    led_result_t res;
    if (rst) begin
      clear_leds();
    end else begin
      if (wr_en) apply_setting(wr_index, wr_data);
      if (s_tvalid && s_tready) begin
        advance_leds(s_tdata[1:0], s_tdata[4:2], s_tdata[7:5], res);
        predicted_q.push_back(res);
      end
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    led_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (predicted_q.size() == 0) begin
        $error("result beat with no prediction waiting: tdata %h", m_tdata);
        n_fail++;
      end else begin
        want = predicted_q.pop_front();
        if (m_tdata[NUM_LEDS-1:0] !== want.levels) begin
          $error("led_levels mismatch: expected %b, got %b", want.levels,
                 m_tdata[NUM_LEDS-1:0]);
          n_fail++;
        end
        if (m_tdata[2*NUM_LEDS-1:NUM_LEDS] !== want.changed) begin
          $error("changed_mask mismatch: expected %b, got %b", want.changed,
                 m_tdata[2*NUM_LEDS-1:NUM_LEDS]);
          n_fail++;
        end
      end
    end
  end

  // cycles with no beat and no write
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_test
    logic timed_out;

    // directed: every opcode and mode, bad index, unused codes, all at reset settings
    add_beat(OP_TICK,    0, MODE_OFF);
    add_beat(OP_SET_ALL, 0, MODE_HEART);
    add_beat(OP_TICK,    0, MODE_OFF);
    add_beat(OP_SET_ONE, 0, MODE_ON);
    add_beat(OP_SET_ONE, 1, MODE_SLOW);
    add_beat(OP_SET_ONE, 2, MODE_FAST);
    add_beat(OP_SET_ONE, 3, MODE_RAPID);
    add_beat(OP_SET_ONE, 4, MODE_FLASH);
    add_beat(OP_SET_ONE, 5, MODE_UNUSED);
    add_beat(OP_SET_ONE, 6, MODE_OFF);
    add_beat(OP_SET_ONE, 7, MODE_UNUSED);
    add_beat(OP_UNUSED,  7, MODE_UNUSED);
    add_beat(OP_TICK,    7, MODE_UNUSED);
    add_beat(OP_TICK,    0, MODE_OFF);
    add_beat(OP_SET_ALL, 0, MODE_OFF);
    add_beat(OP_TICK,    0, MODE_OFF);
    add_beat(OP_SET_ALL, 0, MODE_UNUSED);
    add_beat(OP_TICK,    0, MODE_OFF);
    add_beat(OP_SET_ALL, 0, MODE_FLASH);
    add_beat(OP_TICK,    0, MODE_OFF);

    // random phases over short, zero, minimal, maximal and random settings
    add_setting(3, 2, 1, 4, 300);
    add_random_beats(300);
    add_setting(0, 0, 0, 0, 0);
    add_random_beats(150);
    add_setting(1, 1, 1, 1, 1);
    add_random_beats(150);
    add_setting(7, 5, 2, 9, 301);
    add_random_beats(350);
    add_setting(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    add_random_beats(200);
    add_setting($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                $urandom_range(1, 12), $urandom_range(300, 420));
    add_random_beats(350);
    add_setting($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30),
                $urandom_range(0, 30), $urandom_range(300, CFG_MAX));
    add_random_beats(250);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // run until all stimulus is in and every result is back
    @(negedge clk);
    while ((stimulus_q.size() != 0 || s_tvalid || beats_sent != results_seen) &&
           idle_cycles < STALL_LIMIT)
      @(negedge clk);
    timed_out = (idle_cycles >= STALL_LIMIT);

    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(negedge clk);
      while (predicted_q.size() != 0) begin
        $error("prediction never matched by a result: levels %b",
               predicted_q[0].levels);
        void'(predicted_q.pop_front());
        n_fail++;
      end
    end

    if (!timed_out && n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
